/* rtl/core/size_class_disk_allocator_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the size-class disk allocator
// Clocked implication checks used by the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_DISK_ALLOCATOR_TOP_ASSERT_SVH
`define SIZE_CLASS_DISK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define SCDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SCDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/scda_pkg.sv */
// ----------------------------------------------------------------------------
// scda_pkg
// Shared types, codes and the size-class table of the disk allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package scda_pkg;

    // Fixed field widths of the streaming interface
    localparam int NUM_CLASSES = 44;
    localparam int CLASS_W     = 6;
    localparam int LEN_W       = 24;
    localparam int FIELD_W     = 40;
    localparam int STATUS_W    = 3;
    localparam int IN_DATA_W   = 104;
    localparam int OUT_DATA_W  = 192;
    localparam int MAX_ENTRY   = 10 << 20;

    // Defaults of the top-level parameters
    localparam int DEF_DEAD_DEPTH      = 64;
    localparam int DEF_ADDR_BITS       = 40;
    localparam int DEF_SLOTS_PER_BLOCK = 512;
    localparam int DEF_BLOCK_BYTES     = 65536;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_REUSED      = 3'd0,
        STAT_FRESH       = 3'd1,
        STAT_FRESH_BLOCK = 3'd2,
        STAT_FREED       = 3'd3,
        STAT_BAD_SIZE    = 3'd4,
        STAT_LIST_FULL   = 3'd5,
        STAT_TOO_LARGE   = 3'd6
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_POP
    } state_t;

    // Class lookup result
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic               exact;
        logic               too_large;
    } class_info_t;

    // Allocation bytes of each size class
    function automatic logic [LEN_W-1:0] class_bytes(input logic [CLASS_W-1:0] idx);
        logic [LEN_W-1:0] b;
        case (idx)
            6'd0:    b = 24'd128;
            6'd1:    b = 24'd256;
            6'd2:    b = 24'd384;
            6'd3:    b = 24'd512;
            6'd4:    b = 24'd640;
            6'd5:    b = 24'd768;
            6'd6:    b = 24'd896;
            6'd7:    b = 24'd1024;
            6'd8:    b = 24'd1152;
            6'd9:    b = 24'd1280;
            6'd10:   b = 24'd1664;
            6'd11:   b = 24'd2176;
            6'd12:   b = 24'd2944;
            6'd13:   b = 24'd3840;
            6'd14:   b = 24'd4992;
            6'd15:   b = 24'd6528;
            6'd16:   b = 24'd8576;
            6'd17:   b = 24'd11264;
            6'd18:   b = 24'd14720;
            6'd19:   b = 24'd19200;
            6'd20:   b = 24'd24960;
            6'd21:   b = 24'd32512;
            6'd22:   b = 24'd42368;
            6'd23:   b = 24'd55168;
            6'd24:   b = 24'd71808;
            6'd25:   b = 24'd93440;
            6'd26:   b = 24'd121472;
            6'd27:   b = 24'd157952;
            6'd28:   b = 24'd205440;
            6'd29:   b = 24'd267136;
            6'd30:   b = 24'd347392;
            6'd31:   b = 24'd451712;
            6'd32:   b = 24'd587264;
            6'd33:   b = 24'd763520;
            6'd34:   b = 24'd992640;
            6'd35:   b = 24'd1290496;
            6'd36:   b = 24'd1677696;
            6'd37:   b = 24'd2181120;
            6'd38:   b = 24'd2835456;
            6'd39:   b = 24'd3686144;
            6'd40:   b = 24'd4792064;
            6'd41:   b = 24'd6229760;
            6'd42:   b = 24'd8098688;
            6'd43:   b = 24'd10485760;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/scda_ram.sv */
// ----------------------------------------------------------------------------
// scda_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/scda_class_lookup.sv */
// ----------------------------------------------------------------------------
// scda_class_lookup
// Rounds a length up to its size class and flags exact and oversize lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module scda_class_lookup (
    input  wire logic [scda_pkg::LEN_W-1:0] len,
    output scda_pkg::class_info_t           info
);

    import scda_pkg::*;

    logic [CLASS_W-1:0] cls;

    // The table is ascending: the class is the count of sizes below len
    always_comb
    begin
        cls = '0;
        for (int c = 0; c < NUM_CLASSES - 1; c++)
        begin
            if (len > class_bytes(CLASS_W'(c)))
            begin
                cls = CLASS_W'(c + 1);
            end
        end
    end

    assign info.cls       = cls;
    assign info.exact     = (len == class_bytes(cls));
    assign info.too_large = (len > LEN_W'(MAX_ENTRY));

endmodule

`default_nettype wire

/* rtl/core/size_class_disk_allocator_top.sv */
// ----------------------------------------------------------------------------
// size_class_disk_allocator_top
// Segregated free-list extent allocator over 44 fixed size classes. One
// command is handled at a time: a transfer is taken in the idle cycle, the
// class is looked up and its dead-list count read from RAM in the next cycle,
// and the decision cycle writes the count back and loads the result register.
// A reuse allocate adds a pop step, since the popped pair is read from the
// dead-list RAM once its address is known. The result register frees the
// output side: the next command is taken while a result still waits, and a
// command only stalls in its decision or pop step while an older result is
// not taken. Dead-list counts reset to zero through per-class valid flags,
// so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "size_class_disk_allocator_top_assert.svh"

module size_class_disk_allocator_top #(
    parameter int DEAD_DEPTH      = scda_pkg::DEF_DEAD_DEPTH,
    parameter int ADDR_BITS       = scda_pkg::DEF_ADDR_BITS,
    parameter int SLOTS_PER_BLOCK = scda_pkg::DEF_SLOTS_PER_BLOCK,
    parameter int BLOCK_BYTES     = scda_pkg::DEF_BLOCK_BYTES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Command stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // length[23:0], slot_offset_in[63:24], extent_start_in[103:64]
    input  wire logic [scda_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command[0]
    input  wire logic                              s_axis_tuser,
    // Result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // slot_offset[39:0], extent_start[79:40], alloc_size[103:80],
    // size_class[109:104], new_block_offset[149:110],
    // link_block_offset[189:150], zero pad[191:190]
    output logic      [scda_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // status[2:0]
    output logic      [scda_pkg::STATUS_W-1:0]     m_axis_tuser
);

    import scda_pkg::*;

    // Derived sizes and constants
    localparam int CNT_W     = $clog2(DEAD_DEPTH + 1);
    localparam int FSC_W     = $clog2(SLOTS_PER_BLOCK + 1);
    localparam int ST_DEPTH  = NUM_CLASSES * DEAD_DEPTH;
    localparam int SA_W      = $clog2(ST_DEPTH);
    localparam int STRIDE    = BLOCK_BYTES / SLOTS_PER_BLOCK;
    localparam logic [ADDR_BITS-1:0] BLOCK_A     = ADDR_BITS'(BLOCK_BYTES);
    localparam logic [ADDR_BITS-1:0] STRIDE_A    = ADDR_BITS'(STRIDE);
    localparam logic [ADDR_BITS-1:0] TOP_SLOT_A  = ADDR_BITS'((SLOTS_PER_BLOCK - 1) * STRIDE);
    localparam logic [ADDR_BITS-1:0] SLOT_END_A  = ADDR_BITS'(SLOTS_PER_BLOCK * STRIDE);
    localparam logic [FSC_W-1:0]     FSC_FULL    = FSC_W'(SLOTS_PER_BLOCK);
    localparam logic [FSC_W-1:0]     FSC_TOP     = FSC_W'(SLOTS_PER_BLOCK - 1);
    localparam logic [CNT_W-1:0]     CNT_LIMIT   = CNT_W'(DEAD_DEPTH);

    // Sequencer and allocator state
    state_t                 state_reg, state_next;
    logic [ADDR_BITS-1:0]   file_len_reg, file_len_next;
    logic [ADDR_BITS-1:0]   last_blk_reg, last_blk_next;
    logic [FSC_W-1:0]       fsc_reg, fsc_next;
    logic [ADDR_BITS-1:0]   slot_ptr_reg, slot_ptr_next;
    logic [NUM_CLASSES-1:0] cnt_valid_reg, cnt_valid_next;
    logic                   out_valid_reg, out_valid_next;

    // Latched command and its class
    logic                 cmd_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [FIELD_W-1:0]   slot_in_reg;
    logic [FIELD_W-1:0]   start_in_reg;
    class_info_t          info;
    class_info_t          info_reg;

    // Result register
    status_t              out_status_reg, out_status_next;
    logic [FIELD_W-1:0]   out_slot_reg, out_slot_next;
    logic [FIELD_W-1:0]   out_start_reg, out_start_next;
    logic [LEN_W-1:0]     out_size_reg, out_size_next;
    logic [CLASS_W-1:0]   out_class_reg, out_class_next;
    logic [FIELD_W-1:0]   out_nblk_reg, out_nblk_next;
    logic [FIELD_W-1:0]   out_link_reg, out_link_next;
    logic                 out_load;
    logic                 out_free;
    logic                 s_accept;

    // Memory ports
    logic                   cnt_re, cnt_we;
    logic [CNT_W-1:0]       cnt_wdata, cnt_rdata, cnt_cur;
    logic                   st_re, st_we;
    logic [CNT_W-1:0]       st_idx;
    logic [SA_W-1:0]        st_addr;
    logic [2*ADDR_BITS-1:0] st_wdata, st_rdata;

    // Fresh-allocation datapath
    logic                 need_blk;
    logic [LEN_W-1:0]     cls_size;
    logic [ADDR_BITS-1:0] fresh_start;
    logic [ADDR_BITS-1:0] fresh_slot;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Class lookup of the latched length
    scda_class_lookup u_lookup (
        .len  (len_reg),
        .info (info)
    );

    // Dead-list counts, one per class
    scda_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_CLASSES),
        .AW    (CLASS_W)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (info_reg.cls),
        .wr_data (cnt_wdata),
        .rd_en   (cnt_re),
        .rd_addr (info.cls),
        .rd_data (cnt_rdata)
    );

    // Dead-list pairs, {start, slot} per entry
    scda_ram #(
        .WIDTH (2 * ADDR_BITS),
        .DEPTH (ST_DEPTH),
        .AW    (SA_W)
    ) u_store_ram (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_addr),
        .wr_data (st_wdata),
        .rd_en   (st_re),
        .rd_addr (st_addr),
        .rd_data (st_rdata)
    );

    // Counts never written since reset read as zero
    assign cnt_cur  = cnt_valid_reg[info_reg.cls] ? cnt_rdata : '0;
    assign st_addr  = SA_W'(info_reg.cls) * SA_W'(DEAD_DEPTH) + SA_W'(st_idx);
    assign st_wdata = {ADDR_BITS'(start_in_reg), ADDR_BITS'(slot_in_reg)};

    // Fresh grant: open a block at the file end when its slots are used up
    assign cls_size    = class_bytes(info_reg.cls);
    assign need_blk    = (fsc_reg == '0);
    assign fresh_start = need_blk ? (file_len_reg + BLOCK_A) : file_len_reg;
    assign fresh_slot  = need_blk ? (file_len_reg + TOP_SLOT_A) : (slot_ptr_reg - STRIDE_A);

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        file_len_next   = file_len_reg;
        last_blk_next   = last_blk_reg;
        fsc_next        = fsc_reg;
        slot_ptr_next   = slot_ptr_reg;
        cnt_valid_next  = cnt_valid_reg;
        s_axis_tready   = 1'b0;
        cnt_re          = 1'b0;
        cnt_we          = 1'b0;
        cnt_wdata       = cnt_cur;
        st_re           = 1'b0;
        st_we           = 1'b0;
        st_idx          = cnt_cur;
        out_load        = 1'b0;
        out_status_next = STAT_REUSED;
        out_slot_next   = '0;
        out_start_next  = '0;
        out_size_next   = '0;
        out_class_next  = '0;
        out_nblk_next   = '0;
        out_link_next   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                cnt_re     = 1'b1;
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if (info_reg.too_large)
                        begin
                            out_load        = 1'b1;
                            out_status_next = STAT_TOO_LARGE;
                        end
                        else if (cnt_cur != '0)
                        begin
                            // Pop the top pair; the result is loaded in the pop state once the output is free
                            cnt_we                       = 1'b1;
                            cnt_wdata                    = cnt_cur - CNT_W'(1);
                            cnt_valid_next[info_reg.cls] = 1'b1;
                            st_idx                       = cnt_cur - CNT_W'(1);
                            st_re                        = 1'b1;
                            state_next                   = S_POP;
                        end
                        else
                        begin
                            // Grant a fresh slot and grow the file
                            out_load       = 1'b1;
                            out_size_next  = cls_size;
                            out_class_next = info_reg.cls;
                            out_slot_next  = FIELD_W'(fresh_slot);
                            out_start_next = FIELD_W'(fresh_start);
                            slot_ptr_next  = fresh_slot;
                            file_len_next  = fresh_start + ADDR_BITS'(cls_size);
                            if (need_blk)
                            begin
                                out_status_next = STAT_FRESH_BLOCK;
                                out_nblk_next   = FIELD_W'(file_len_reg);
                                out_link_next   = FIELD_W'(last_blk_reg);
                                last_blk_next   = file_len_reg;
                                fsc_next        = FSC_TOP;
                            end
                            else
                            begin
                                out_status_next = STAT_FRESH;
                                fsc_next        = fsc_reg - FSC_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        out_load = 1'b1;
                        if (!info_reg.exact)
                        begin
                            out_status_next = STAT_BAD_SIZE;
                        end
                        else if (cnt_cur >= CNT_LIMIT)
                        begin
                            out_status_next = STAT_LIST_FULL;
                            out_size_next   = cls_size;
                            out_class_next  = info_reg.cls;
                        end
                        else
                        begin
                            // Push the pair onto the class dead list
                            st_we                        = 1'b1;
                            cnt_we                       = 1'b1;
                            cnt_wdata                    = cnt_cur + CNT_W'(1);
                            cnt_valid_next[info_reg.cls] = 1'b1;
                            out_status_next              = STAT_FREED;
                            out_size_next                = cls_size;
                            out_class_next               = info_reg.cls;
                        end
                    end
                end
            end

            S_POP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = STAT_REUSED;
                    out_slot_next   = FIELD_W'(st_rdata[ADDR_BITS-1:0]);
                    out_start_next  = FIELD_W'(st_rdata[2*ADDR_BITS-1:ADDR_BITS]);
                    out_size_next   = cls_size;
                    out_class_next  = info_reg.cls;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    // Control and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            file_len_reg  <= BLOCK_A;
            last_blk_reg  <= '0;
            fsc_reg       <= FSC_FULL;
            slot_ptr_reg  <= SLOT_END_A;
            cnt_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            file_len_reg  <= file_len_next;
            last_blk_reg  <= last_blk_next;
            fsc_reg       <= fsc_next;
            slot_ptr_reg  <= slot_ptr_next;
            cnt_valid_reg <= cnt_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Latch the command on transfer, the class once looked up
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg      <= s_axis_tuser;
            len_reg      <= s_axis_tdata[23:0];
            slot_in_reg  <= s_axis_tdata[63:24];
            start_in_reg <= s_axis_tdata[103:64];
        end
        if (state_reg == S_READ)
        begin
            info_reg <= info;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_start_reg  <= out_start_next;
            out_size_reg   <= out_size_next;
            out_class_reg  <= out_class_next;
            out_nblk_reg   <= out_nblk_next;
            out_link_reg   <= out_link_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {2'b00, out_link_reg, out_nblk_reg, out_class_reg,
                            out_size_reg, out_start_reg, out_slot_reg};

    // Checks
    `SCDA_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_accept, !s_axis_tready,
        "command taken while another is in flight")
    `SCDA_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_load,
        (!m_axis_tvalid || m_axis_tready), "pending result overwritten")
    `SCDA_ASSERT_IMP(a_push_in_range, clk, rst_n, st_we, (cnt_cur < CNT_LIMIT),
        "push into a full dead list")
    `SCDA_ASSERT_IMP(a_rise_from_decide, clk, rst_n, $rose(m_axis_tvalid),
        ($past(state_reg) == S_DECIDE || $past(state_reg) == S_POP),
        "result appeared outside a decision step")

endmodule

`default_nettype wire
